>>> rtl/core/checked_unsigned_alu_assert.svh
// Assertion macros for the checked unsigned ALU.
// Used by checked_unsigned_alu.sv; expects clk_i and rst_ni in scope.
`ifndef CHECKED_UNSIGNED_ALU_ASSERT_SVH
`define CHECKED_UNSIGNED_ALU_ASSERT_SVH

`ifndef SYNTH
// checked with reset masked off
`define CUA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("checked_unsigned_alu assertion failed");
// checked during reset too
`define CUA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("checked_unsigned_alu reset assertion failed");
`else
`define CUA_ASSERT(lbl, prop)
`define CUA_ASSERT_RST(lbl, prop)
`endif

`endif

>>> rtl/core/cua_pkg.sv
// Shared types and constants for the checked unsigned ALU.
// No dependencies; imported by every cua_* module and the top level.
package cua_pkg;

  localparam int MaxW     = 64;
  localparam int DefWidth = 64;

  typedef enum logic [4:0] {
    OpAdd  = 5'd0,  OpSub = 5'd1,  OpMul = 5'd2,  OpDiv  = 5'd3,
    OpMod  = 5'd4,  OpAnd = 5'd5,  OpOr  = 5'd6,  OpXor  = 5'd7,
    OpShl  = 5'd8,  OpShr = 5'd9,  OpLnot = 5'd10, OpLand = 5'd11,
    OpLor  = 5'd12, OpEq  = 5'd13, OpNe  = 5'd14, OpLt   = 5'd15,
    OpLe   = 5'd16, OpGt  = 5'd17, OpGe  = 5'd18, OpInc  = 5'd19,
    OpDec  = 5'd20
  } op_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StOver   = 2'd1,
    StUnder  = 2'd2,
    StDomain = 2'd3
  } st_e;

  // request context carried down the pipeline
  typedef struct packed {
    logic [4:0]      op;
    logic [MaxW-1:0] a;
    logic [MaxW-1:0] mag;      // magnitude of the selected right operand
    logic [MaxW-1:0] divisor;  // mag for div, reduced operand for mod
    logic [MaxW-1:0] pre_res;  // result of the operations finished at decode
    logic [1:0]      pre_st;
  } side_t;

endpackage

>>> rtl/core/cua_div_step.sv
// One restoring division step: one quotient bit per register stage.
// Depends on cua_pkg.
module cua_div_step #(
  parameter int BIT = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  cua_pkg::side_t              side_i,
  input  logic [cua_pkg::MaxW-1:0]    rem_i,
  input  logic [cua_pkg::MaxW-1:0]    quo_i,
  output logic                        valid_o,
  output cua_pkg::side_t              side_o,
  output logic [cua_pkg::MaxW-1:0]    rem_o,
  output logic [cua_pkg::MaxW-1:0]    quo_o
);
  import cua_pkg::*;

  logic            valid_q;
  side_t           side_q;
  logic [MaxW-1:0] rem_d, rem_q, quo_d, quo_q;
  logic [MaxW:0]   shifted, diff;
  logic            ge;

  always_comb begin
    shifted = {rem_i, side_i.a[BIT]};
    diff    = shifted - {1'b0, side_i.divisor};
    ge      = shifted >= {1'b0, side_i.divisor};
    rem_d   = ge ? diff[MaxW-1:0] : shifted[MaxW-1:0];
    quo_d   = quo_i;
    quo_d[BIT] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;

endmodule

>>> rtl/core/cua_div.sv
// Pipelined restoring divider, WIDTH stages, MSB first.
// Depends on cua_pkg and cua_div_step.
module cua_div #(
  parameter int WIDTH = cua_pkg::DefWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  cua_pkg::side_t            side_i,
  output logic                      valid_o,
  output cua_pkg::side_t            side_o,
  output logic [cua_pkg::MaxW-1:0]  rem_o,
  output logic [cua_pkg::MaxW-1:0]  quo_o
);
  import cua_pkg::*;

  logic            valid_c [WIDTH+1];
  side_t           side_c  [WIDTH+1];
  logic [MaxW-1:0] rem_c   [WIDTH+1];
  logic [MaxW-1:0] quo_c   [WIDTH+1];

  assign valid_c[0] = valid_i;
  assign side_c[0]  = side_i;
  assign rem_c[0]   = '0;
  assign quo_c[0]   = '0;

  for (genvar i = 0; i < WIDTH; i++) begin : g_step
    cua_div_step #(
      .BIT(WIDTH - 1 - i)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(valid_c[i]),
      .side_i (side_c[i]),
      .rem_i  (rem_c[i]),
      .quo_i  (quo_c[i]),
      .valid_o(valid_c[i+1]),
      .side_o (side_c[i+1]),
      .rem_o  (rem_c[i+1]),
      .quo_o  (quo_c[i+1])
    );
  end

  assign valid_o = valid_c[WIDTH];
  assign side_o  = side_c[WIDTH];
  assign rem_o   = rem_c[WIDTH];
  assign quo_o   = quo_c[WIDTH];

endmodule

>>> rtl/core/cua_mul.sv
// Two-stage multiplier: 32x32 partial products, then a registered sum
// with the range check. Depends on cua_pkg.
module cua_mul #(
  parameter int WIDTH = cua_pkg::DefWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  cua_pkg::side_t            side_i,
  input  logic [cua_pkg::MaxW-1:0]  quo_i,
  input  logic [cua_pkg::MaxW-1:0]  rem_i,
  output logic                      valid_o,
  output cua_pkg::side_t            side_o,
  output logic [cua_pkg::MaxW-1:0]  quo_o,
  output logic [cua_pkg::MaxW-1:0]  rem_o,
  output logic [cua_pkg::MaxW-1:0]  prod_o,
  output logic                      ovf_o
);
  import cua_pkg::*;

  localparam int HalfW = MaxW / 2;
  localparam logic [2*MaxW-1:0] HighMask = ~(((2*MaxW)'(1) << WIDTH) - (2*MaxW)'(1));

  // stage 1
  logic            v1_q;
  side_t           side1_q;
  logic [MaxW-1:0] quo1_q, rem1_q;
  logic [MaxW-1:0] pll_q, plh_q, phl_q, phh_q;
  // stage 2
  logic            v2_q;
  side_t           side2_q;
  logic [MaxW-1:0] quo2_q, rem2_q, prod_q;
  logic            ovf_q;
  logic [2*MaxW-1:0] prod_full;

  always_comb begin
    prod_full = {{MaxW{1'b0}}, pll_q}
              + {{HalfW{1'b0}}, plh_q, {HalfW{1'b0}}}
              + {{HalfW{1'b0}}, phl_q, {HalfW{1'b0}}}
              + {phh_q, {MaxW{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      quo1_q  <= quo_i;
      rem1_q  <= rem_i;
      pll_q   <= side_i.a[HalfW-1:0]    * side_i.mag[HalfW-1:0];
      plh_q   <= side_i.a[HalfW-1:0]    * side_i.mag[MaxW-1:HalfW];
      phl_q   <= side_i.a[MaxW-1:HalfW] * side_i.mag[HalfW-1:0];
      phh_q   <= side_i.a[MaxW-1:HalfW] * side_i.mag[MaxW-1:HalfW];
      side2_q <= side1_q;
      quo2_q  <= quo1_q;
      rem2_q  <= rem1_q;
      prod_q  <= prod_full[MaxW-1:0];
      ovf_q   <= |(prod_full & HighMask);
    end
  end

  assign valid_o = v2_q;
  assign side_o  = side2_q;
  assign quo_o   = quo2_q;
  assign rem_o   = rem2_q;
  assign prod_o  = prod_q;
  assign ovf_o   = ovf_q;

endmodule

>>> rtl/core/checked_unsigned_alu.sv
// Checked unsigned ALU, WIDTH bits (8..64). A request is decoded into a
// register stage, runs through a WIDTH-stage restoring divider and a
// two-stage multiplier, and lands in an output register. One request can
// enter every cycle while the pipeline is not stalled. The whole pipeline
// advances together; it holds while the output register is full and
// stalled, and in_stall_o then goes high. Results that leave the range
// or the domain of the operation are flagged in status_o and read as zero.
// Depends on cua_pkg, cua_div, cua_mul and checked_unsigned_alu_assert.svh.
`include "checked_unsigned_alu_assert.svh"

module checked_unsigned_alu #(
  parameter int WIDTH = cua_pkg::DefWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  operation_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  input  logic [31:0] operand_b_int_i,
  input  logic        b_is_signed_i,
  input  logic [7:0]  shift_amount_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_o,
  output logic [1:0]  status_o
);
  import cua_pkg::*;

  localparam logic [MaxW:0]   MaskW  = ((MaxW+1)'(1) << WIDTH) - (MaxW+1)'(1);
  localparam logic [MaxW-1:0] Mask   = MaskW[MaxW-1:0];
  localparam logic [8:0]      WidthL = 9'(WIDTH);

  logic en;

  // decode
  logic [MaxW-1:0] a, bu, sext, mag, red, res;
  logic [MaxW:0]   sum;
  logic            sgn, neg, add_like, long_sh;
  logic [1:0]      st;
  side_t           side_d, d_side_q;
  logic            d_valid_q;

  always_comb begin
    a        = operand_a_i & Mask;
    bu       = operand_b_i & Mask;
    sgn      = b_is_signed_i;
    neg      = sgn & operand_b_int_i[31];
    sext     = {{(MaxW-32){operand_b_int_i[31]}}, operand_b_int_i};
    mag      = neg ? (~sext + MaxW'(1)) : (sgn ? {{(MaxW-32){1'b0}}, operand_b_int_i} : bu);
    red      = sgn ? (sext & Mask) : bu;
    sum      = {1'b0, a} + {1'b0, mag};
    add_like = (operation_i == OpAdd && !neg) || (operation_i == OpSub && neg);
    long_sh  = {1'b0, shift_amount_i} >= WidthL;
    res      = '0;
    st       = StOk;
    case (operation_i)
      OpAdd, OpSub: begin
        if (add_like) begin
          if (|(sum & ~MaskW)) st = StOver;
          else res = sum[MaxW-1:0];
        end else begin
          if (a < mag) st = StUnder;
          else res = a - mag;
        end
      end
      OpMul: begin
        if (a == '0 || mag == '0) st = StDomain;
        else if (neg) st = StUnder;
      end
      OpDiv: begin
        if (mag == '0 || neg || (!sgn && a == '0)) st = StDomain;
      end
      OpMod: begin
        if (a == '0 || mag == '0 || red == '0) st = StDomain;
      end
      OpAnd, OpOr, OpXor: begin
        if (neg) st = StDomain;
        else if (operation_i == OpAnd) res = a & red;
        else if (operation_i == OpOr) res = a | red;
        else res = a ^ red;
      end
      OpShl:  res = long_sh ? '0 : ((a << shift_amount_i[5:0]) & Mask);
      OpShr:  res = long_sh ? '0 : (a >> shift_amount_i[5:0]);
      OpLnot: res = MaxW'(a == '0);
      OpLand: res = MaxW'(a != '0 && mag != '0);
      OpLor:  res = MaxW'(a != '0 || mag != '0);
      OpEq:   res = MaxW'(!neg && a == mag);
      OpNe:   res = MaxW'(neg || a != mag);
      OpLt:   res = MaxW'(!neg && a < mag);
      OpLe:   res = MaxW'(!neg && a <= mag);
      OpGt:   res = MaxW'(neg || a > mag);
      OpGe:   res = MaxW'(neg || a >= mag);
      OpInc: begin
        if (a == Mask) st = StOver;
        else res = a + MaxW'(1);
      end
      OpDec: begin
        if (a == '0) st = StUnder;
        else res = a - MaxW'(1);
      end
      default: st = StDomain;
    endcase
    side_d.op      = operation_i;
    side_d.a       = a;
    side_d.mag     = mag;
    side_d.divisor = (operation_i == OpMod) ? red : mag;
    side_d.pre_res = res;
    side_d.pre_st  = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_side_q <= side_d;
    end
  end

  // divider
  logic            dv_valid;
  side_t           dv_side;
  logic [MaxW-1:0] dv_rem, dv_quo;

  cua_div #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(d_valid_q),
    .side_i (d_side_q),
    .valid_o(dv_valid),
    .side_o (dv_side),
    .rem_o  (dv_rem),
    .quo_o  (dv_quo)
  );

  // multiplier
  logic            mu_valid, mu_ovf;
  side_t           mu_side;
  logic [MaxW-1:0] mu_quo, mu_rem, mu_prod;

  cua_mul #(
    .WIDTH(WIDTH)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(dv_valid),
    .side_i (dv_side),
    .quo_i  (dv_quo),
    .rem_i  (dv_rem),
    .valid_o(mu_valid),
    .side_o (mu_side),
    .quo_o  (mu_quo),
    .rem_o  (mu_rem),
    .prod_o (mu_prod),
    .ovf_o  (mu_ovf)
  );

  // result select and output register
  logic [MaxW-1:0] result_d, result_q, fin_res;
  logic [1:0]      status_d, status_q;
  logic            out_valid_q;

  always_comb begin
    fin_res  = mu_side.pre_res;
    status_d = mu_side.pre_st;
    if (mu_side.pre_st == StOk) begin
      if (mu_side.op == OpMul) begin
        if (mu_ovf) status_d = StOver;
        else fin_res = mu_prod;
      end else if (mu_side.op == OpDiv) begin
        fin_res = mu_quo;
      end else if (mu_side.op == OpMod) begin
        fin_res = mu_rem;
      end
    end
    result_d = (status_d == StOk) ? (fin_res & Mask) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= mu_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_q <= result_d;
      status_q <= status_d;
    end
  end

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign status_o    = status_q;

  `CUA_ASSERT(a_fail_zero, out_valid_o && status_o != StOk |-> result_o == '0)
  `CUA_ASSERT(a_in_range, out_valid_o |-> (result_o & ~Mask) == '0)
  `CUA_ASSERT(a_mul_range, mu_valid && mu_side.op == OpMul && mu_side.pre_st == StOk && !mu_ovf |-> (mu_prod & ~Mask) == '0)
  `CUA_ASSERT_RST(a_reset_empty, !rst_ni |-> !out_valid_o && !d_valid_q)

endmodule
